// ----- hdl/mfb_pkg.sv -----
// shared constants, command codes and controller/datapath types
// for the monochrome frame buffer draw block; no dependencies
package mfb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int BYTE_W        = 8;

  // signed coordinate width for the line walker, unsigned for the rect walker
  localparam int CRD_W = 10;
  localparam int RC_W  = 9;

  typedef enum logic [1:0] {
    FUNC_LINE  = 2'd0,
    FUNC_FILL  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic setup;
    logic rd_byte;
    logic pix_rd;
    logic pix_wr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic empty;
    logic last;
    logic out_busy;
  } ctrl_stat_t;

endpackage

// ----- hdl/mfb_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/mfb_datapath.sv -----
// datapath: command registers, line and rectangle walkers, pixel
// read-modify-write on the buffer ram, result register; uses mfb_pkg, mfb_ram
module mfb_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mfb_pkg::ctrl_cmd_t    cmd,
  output mfb_pkg::ctrl_stat_t   stat,
  input  logic [1:0]            in_func,
  input  logic [6:0]            in_x_start,
  input  logic [5:0]            in_y_start,
  input  logic [7:0]            in_x_end,
  input  logic [6:0]            in_y_end,
  input  logic [7:0]            in_rect_width,
  input  logic [6:0]            in_rect_height,
  input  logic [9:0]            in_byte_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_read_data
);

  localparam int CW = mfb_pkg::CRD_W;
  localparam int RW = mfb_pkg::RC_W;
  localparam int AW = mfb_pkg::ADDR_W;
  localparam int BW = mfb_pkg::BYTE_W;

  // command registers
  logic [1:0] func_r;
  logic [6:0] xs_r;
  logic [5:0] ys_r;
  logic [7:0] xe_r;
  logic [6:0] ye_r;
  logic [7:0] w_r;
  logic [6:0] h_r;
  logic [9:0] idx_r;

  // line walker
  logic signed [CW-1:0] a_r, a_nxt, b_r, b_nxt, aend_r, aend_nxt;
  logic signed [CW-1:0] err_r, err_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic                 steep_r, steep_nxt, yneg_r, yneg_nxt, line_r, line_nxt;

  // rectangle walker
  logic [RW-1:0] col_r, col_nxt, row_r, row_nxt, c1_r, c1_nxt, r0_r, r0_nxt, r1_r, r1_nxt;
  logic          on_r, on_nxt;

  logic [AW-1:0] clr_cnt_r;
  logic          out_valid_r;
  logic [BW-1:0] out_data_r;

  // setup terms
  logic signed [CW-1:0] x0, y0, x1, y1, ddx, ddy, dxa, dya;
  logic signed [CW-1:0] sx0, sy0, sx1, sy1, ox0, oy0, ox1, oy1, ldx, ldy;
  logic                 steep;
  logic [RW-1:0]        c0, c1, r0, r1;
  logic                 is_fill;

  // pixel terms
  logic signed [CW-1:0] px, py, e2;
  logic                 onscreen;
  logic [AW-1:0]        pix_addr;
  logic [BW-1:0]        mask, rdata, mod_data;
  logic                 idx_ok;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [BW-1:0]        ram_wdata;
  logic [RW-1:0]        row_inc, col_inc;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      xs_r   <= in_x_start;
      ys_r   <= in_y_start;
      xe_r   <= in_x_end;
      ye_r   <= in_y_end;
      w_r    <= in_rect_width;
      h_r    <= in_rect_height;
      idx_r  <= in_byte_index;
    end
  end

  // steep swap, then endpoint order swap
  always_comb begin
    x0  = CW'(xs_r);
    y0  = CW'(ys_r);
    x1  = CW'(xe_r);
    y1  = CW'(ye_r);
    ddx = x1 - x0;
    ddy = y1 - y0;
    dxa = (ddx < 0) ? -ddx : ddx;
    dya = (ddy < 0) ? -ddy : ddy;
    steep = dya > dxa;
    sx0 = steep ? y0 : x0;
    sy0 = steep ? x0 : y0;
    sx1 = steep ? y1 : x1;
    sy1 = steep ? x1 : y1;
    ox0 = (sx0 > sx1) ? sx1 : sx0;
    oy0 = (sx0 > sx1) ? sy1 : sy0;
    ox1 = (sx0 > sx1) ? sx0 : sx1;
    oy1 = (sx0 > sx1) ? sy0 : sy1;
    ldx = ox1 - ox0;
    ldy = (oy1 < oy0) ? (oy0 - oy1) : (oy1 - oy0);
  end

  // fill and clear both become a half-open column/row range
  always_comb begin
    is_fill = func_r == mfb_pkg::FUNC_FILL;
    c0 = RW'(xs_r);
    r0 = RW'(ys_r);
    c1 = is_fill ? (RW'(xs_r) + RW'(w_r)) : RW'(xe_r);
    r1 = is_fill ? (RW'(ys_r) + RW'(h_r)) : RW'(ye_r);
  end

  always_comb begin
    px = line_r ? (steep_r ? b_r : a_r) : CW'(col_r);
    py = line_r ? (steep_r ? a_r : b_r) : CW'(row_r);
    onscreen = (px >= 0) && (px < signed'(CW'(mfb_pkg::SCREEN_WIDTH))) &&
               (py >= 0) && (py < signed'(CW'(mfb_pkg::SCREEN_HEIGHT)));
    pix_addr = AW'(px) + AW'(py >>> 3) * AW'(mfb_pkg::SCREEN_WIDTH);
    mask     = BW'(1) << py[2:0];
    mod_data = on_r ? (rdata | mask) : (rdata & ~mask);
    e2       = err_r - dy_r;
    row_inc  = row_r + RW'(1);
    col_inc  = col_r + RW'(1);
    idx_ok   = 32'(idx_r) < 32'(mfb_pkg::STORE_BYTES);
  end

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    aend_nxt  = aend_r;
    err_nxt   = err_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    steep_nxt = steep_r;
    yneg_nxt  = yneg_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    c1_nxt    = c1_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    on_nxt    = on_r;
    if (cmd.setup) begin
      line_nxt  = func_r == mfb_pkg::FUNC_LINE;
      a_nxt     = ox0;
      b_nxt     = oy0;
      aend_nxt  = ox1;
      dx_nxt    = ldx;
      dy_nxt    = ldy;
      err_nxt   = ldx >>> 1;
      steep_nxt = steep;
      yneg_nxt  = !(oy0 < oy1);
      col_nxt   = c0;
      row_nxt   = r0;
      c1_nxt    = c1;
      r0_nxt    = r0;
      r1_nxt    = r1;
      on_nxt    = func_r != mfb_pkg::FUNC_CLEAR;
    end else if (cmd.pix_wr) begin
      if (line_r) begin
        a_nxt = a_r + CW'(1);
        if (e2 < 0) begin
          b_nxt   = yneg_r ? (b_r - CW'(1)) : (b_r + CW'(1));
          err_nxt = e2 + dx_r;
        end else begin
          err_nxt = e2;
        end
      end else if (row_inc == r1_r) begin
        row_nxt = r0_r;
        col_nxt = col_inc;
      end else begin
        row_nxt = row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    aend_r  <= aend_nxt;
    err_r   <= err_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    steep_r <= steep_nxt;
    yneg_r  <= yneg_nxt;
    line_r  <= line_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    c1_r    <= c1_nxt;
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    on_r    <= on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    ram_we    = cmd.clr_wr || (cmd.pix_wr && onscreen);
    ram_waddr = cmd.clr_wr ? clr_cnt_r : pix_addr;
    ram_wdata = cmd.clr_wr ? '0 : mod_data;
    ram_re    = cmd.rd_byte || cmd.pix_rd;
    ram_raddr = cmd.rd_byte ? AW'(idx_r) : pix_addr;
  end

  mfb_ram #(
    .WIDTH (BW),
    .DEPTH (mfb_pkg::STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // result register parts the two sides
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (func_r == mfb_pkg::FUNC_READ && idx_ok) ? rdata : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  always_comb begin
    stat.clr_last = clr_cnt_r == AW'(mfb_pkg::STORE_BYTES - 1);
    stat.is_read  = func_r == mfb_pkg::FUNC_READ;
    stat.empty    = (func_r == mfb_pkg::FUNC_FILL || func_r == mfb_pkg::FUNC_CLEAR) &&
                    ((c0 >= c1) || (r0 >= r1));
    stat.last     = line_r ? (a_r == aend_r) : ((row_inc == r1_r) && (col_inc == c1_r));
    stat.out_busy = out_valid_r && out_stall;
  end

endmodule

// ----- hdl/mfb_ctrl.sv -----
// controller state machine: clearing pass, command setup, per-pixel
// read/write sequencing, result hand-off; uses mfb_pkg
module mfb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfb_pkg::ctrl_stat_t stat,
  output mfb_pkg::ctrl_cmd_t  cmd
);

  mfb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfb_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      mfb_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = mfb_pkg::ST_IDLE;
        end
      end
      mfb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mfb_pkg::ST_SETUP;
        end
      end
      mfb_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        if (stat.is_read) begin
          cmd.rd_byte = 1'b1;
          state_nxt   = mfb_pkg::ST_DONE;
        end else if (stat.empty) begin
          state_nxt = mfb_pkg::ST_DONE;
        end else begin
          state_nxt = mfb_pkg::ST_RD;
        end
      end
      mfb_pkg::ST_RD: begin
        cmd.pix_rd = 1'b1;
        state_nxt  = mfb_pkg::ST_WR;
      end
      mfb_pkg::ST_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = stat.last ? mfb_pkg::ST_DONE : mfb_pkg::ST_RD;
      end
      mfb_pkg::ST_DONE: begin
        // wait for the previous result beat to leave
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = mfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mfb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/mono_framebuffer_line_rect_draw.sv -----
// Monochrome 128x64 page-organized frame buffer with line, fill, clear and
// byte read commands, one command at a time. After reset the buffer is zeroed
// by a clearing pass over all 1024 bytes during which in_stall stays high. Each
// pixel a command touches is a read-modify-write of one buffer byte through the
// single ram read and write port, a read state and then a write state per pixel:
// a line touches n pixels (n is the longer axis span plus one), a fill or clear
// walks the whole requested rectangle including off-screen pixels, an empty
// rectangle and a byte read touch no pixel. Every command returns one result
// beat; read_data is zero for all but the read command.
// uses mfb_pkg, mfb_ctrl, mfb_datapath
module mono_framebuffer_line_rect_draw (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [6:0] in_x_start,
  input  logic [5:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [6:0] in_y_end,
  input  logic [7:0] in_rect_width,
  input  logic [6:0] in_rect_height,
  input  logic [9:0] in_byte_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);

  mfb_pkg::ctrl_cmd_t  cmd;
  mfb_pkg::ctrl_stat_t stat;

  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_func),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_byte_index  (in_byte_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data)
  );

endmodule

// ----- hdl/mfb_checker.sv -----
// port-level checks on the frame buffer draw block, bound to its top level
// depends only on the top level's ports
module mfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);

  // clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // one command at a time: an accepted beat stalls the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while command in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result beat changed");

  // a result cannot appear in the cycle right after a beat is accepted
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result beat too early");

endmodule

bind mono_framebuffer_line_rect_draw mfb_checker u_mfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data)
);

// ----- sim/tb.sv -----
// testbench for mono_framebuffer_line_rect_draw: random and directed draw, fill,
// clear and read commands, checked against a behavioral frame buffer model
// depends on mfb_pkg and the block's rtl
module tb;

  typedef struct {
    mfb_pkg::func_t func;
    logic [6:0]     x_start;
    logic [5:0]     y_start;
    logic [7:0]     x_end;
    logic [6:0]     y_end;
    logic [7:0]     rect_width;
    logic [6:0]     rect_height;
    logic [9:0]     byte_index;
  } cmd_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [6:0] in_x_start;
  logic [5:0] in_y_start;
  logic [7:0] in_x_end;
  logic [6:0] in_y_end;
  logic [7:0] in_rect_width;
  logic [6:0] in_rect_height;
  logic [9:0] in_byte_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;

  cmd_t       pending_cmds[$];
  logic [7:0] read_q[$];
  logic [7:0] pixel_img[mfb_pkg::STORE_BYTES];
  int         mismatches = 0;
  int         cycle_cnt = 0;
  int         idle_cycles = 0;
  int         results_seen = 0;
  int         hold_cnt = 0;
  bit         held = 0;

  mono_framebuffer_line_rect_draw dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // no idling at all in this window
  function automatic bit calm();
    return cycle_cnt >= 30000 && cycle_cnt < 45000;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic void put_px(int x, int y, bit on);
    int a;
    if (x < 0 || y < 0 || x >= mfb_pkg::SCREEN_WIDTH || y >= mfb_pkg::SCREEN_HEIGHT) return;
    a = x + (y >> 3) * mfb_pkg::SCREEN_WIDTH;
    if (on) pixel_img[a] |= 8'(1 << (y & 7));
    else pixel_img[a] &= ~8'(1 << (y & 7));
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void draw_line(int x0, int y0, int x1, int y1);
    bit steep;
    int t, dx, dy, err, ystep;
    steep = iabs(y1 - y0) > iabs(x1 - x0);
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = iabs(y1 - y0);
    err = dx / 2;
    ystep = (y0 < y1) ? 1 : -1;
    for (; x0 <= x1; x0++) begin
      if (steep) put_px(y0, x0, 1);
      else put_px(x0, y0, 1);
      err -= dy;
      if (err < 0) begin
        y0 += ystep;
        err += dx;
      end
    end
  endfunction

  // applies one command to the model buffer, returns the result byte
  function automatic logic [7:0] apply_cmd(cmd_t c);
    int xs, ys;
    xs = c.x_start;
    ys = c.y_start;
    case (c.func)
      mfb_pkg::FUNC_LINE: draw_line(xs, ys, c.x_end, c.y_end);
      mfb_pkg::FUNC_FILL:
        if (c.rect_height > 0)
          for (int i = xs; i < xs + c.rect_width; i++)
            draw_line(i, ys, i, ys + c.rect_height - 1);
      mfb_pkg::FUNC_CLEAR:
        for (int i = xs; i < c.x_end; i++)
          for (int r = ys; r < c.y_end; r++) put_px(i, r, 0);
      default:
        return c.byte_index < mfb_pkg::STORE_BYTES ? pixel_img[c.byte_index] : 8'd0;
    endcase
    return 8'd0;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.func = mfb_pkg::func_t'($urandom_range(3));
    c.x_start = 7'($urandom_range(127));
    c.y_start = 6'($urandom_range(63));
    c.x_end = 8'($urandom_range(128));
    c.y_end = 7'($urandom_range(64));
    c.rect_width = 8'($urandom_range(128));
    c.rect_height = 7'($urandom_range(64));
    c.byte_index = 10'($urandom_range(1023));
    return c;
  endfunction

  function automatic cmd_t mk(mfb_pkg::func_t f, int xs, int ys, int xe, int ye,
                              int w, int h, int bi);
    cmd_t c;
    c = rand_cmd();
    c.func = f;
    c.x_start = 7'(xs); c.y_start = 6'(ys); c.x_end = 8'(xe); c.y_end = 7'(ye);
    c.rect_width = 8'(w); c.rect_height = 7'(h); c.byte_index = 10'(bi);
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        read_q.push_back(apply_cmd('{mfb_pkg::func_t'(in_func), in_x_start, in_y_start,
                                     in_x_end, in_y_end, in_rect_width, in_rect_height,
                                     in_byte_index}));
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && (calm() || $urandom_range(99) >= 16)) begin
          c = pending_cmds.pop_front();
          in_func <= c.func;
          in_x_start <= c.x_start;
          in_y_start <= c.y_start;
          in_x_end <= c.x_end;
          in_y_end <= c.y_end;
          in_rect_width <= c.rect_width;
          in_rect_height <= c.rect_height;
          in_byte_index <= c.byte_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    logic stall_nxt;
    if (rst_n) begin
      cycle_cnt++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (read_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %0h", out_read_data));
        end else begin
          if (out_read_data !== read_q[0])
            report_mismatch($sformatf("read_data %0h, want %0h", out_read_data, read_q[0]));
          void'(read_q.pop_front());
        end
      end
      // one long hold-off so the block backs up into its input
      if (!held && results_seen == 200) begin
        held = 1;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = !calm() && $urandom_range(99) < 16;
      end
      out_stall <= stall_nxt;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 100000) begin
        $display("timeout");
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    {in_func, in_x_start, in_y_start, in_x_end, in_y_end} = '0;
    {in_rect_width, in_rect_height, in_byte_index} = '0;
    foreach (pixel_img[i]) pixel_img[i] = 8'd0;

    // directed part
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 0, 0, 127, 63, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 127, 0, 0, 63, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 120, 60, 128, 64, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 10, 50, 12, 3, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 90, 5, 40, 9, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_LINE, 33, 33, 33, 33, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1023));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_FILL, 5, 5, 0, 0, 0, 9, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_FILL, 5, 5, 0, 0, 9, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_FILL, 120, 60, 0, 0, 20, 10, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 7 * 128 + 127));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_CLEAR, 50, 10, 40, 20, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_CLEAR, 10, 30, 20, 30, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_CLEAR, 0, 0, 128, 64, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 7 * 128 + 127));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_FILL, 0, 0, 0, 0, 128, 64, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 512));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_CLEAR, 100, 40, 128, 64, 0, 0, 0));
    pending_cmds.push_back(mk(mfb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 6 * 128 + 110));

    // random part, mostly small rectangles with a few of any size up to full screen
    repeat (1000) begin
      c = rand_cmd();
      if (c.func == mfb_pkg::FUNC_FILL && $urandom_range(49) != 0) begin
        c.rect_width = 8'($urandom_range(12));
        c.rect_height = 7'($urandom_range(12));
      end
      if (c.func == mfb_pkg::FUNC_CLEAR && $urandom_range(49) != 0) begin
        c.x_end = 8'(c.x_start + $urandom_range(12) - 2);
        c.y_end = 7'(c.y_start + $urandom_range(12) - 2);
      end
      pending_cmds.push_back(c);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid || read_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mfb_pkg.sv
hdl/mfb_ram.sv
hdl/mfb_datapath.sv
hdl/mfb_ctrl.sv
hdl/mono_framebuffer_line_rect_draw.sv
hdl/mfb_checker.sv
sim/tb.sv
